/* src/dbd_pkg.sv */
// Package for the detection box decoder: payload structs, register indexes,
// field widths and reset values.
// No dependencies; imported by every module of the block.
package dbd_pkg;

  localparam int unsigned VAL_W    = 25;  // signed Q8.16 dequantized element
  localparam int unsigned SCORE_W  = 24;  // unsigned Q8.16 score
  localparam int unsigned COORD_W  = 28;  // signed pixels, Q.4
  localparam int unsigned DIM_W    = 12;  // image dimension in pixels
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned ROW_W    = 16;  // row index as shown on the port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MAX_CLASSES_DEF    = 255;
  localparam int unsigned ROW_INDEX_BITS_DEF = 16;

  localparam logic [7:0]         CLASS_COUNT_RST = 8'd80;
  localparam logic signed [7:0]  IN_OFFSET_RST   = 8'sd0;
  localparam logic [15:0]        SCALE_RST       = 16'd256;
  localparam logic [SCORE_W-1:0] THRESHOLD_RST   = 24'd32768;
  localparam logic [DIM_W-1:0]   WIDTH_RST       = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST      = 12'd480;

  // -1.0 in Q8.16
  localparam logic signed [VAL_W-1:0] MINUS_ONE_Q16 = -25'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_COUNT = 3'd0,
    CFG_IN_OFFSET   = 3'd1,
    CFG_SCALE       = 3'd2,
    CFG_THRESHOLD   = 3'd3,
    CFG_IMG_WIDTH   = 3'd4,
    CFG_IMG_HEIGHT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] raw_value;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
    logic [SCORE_W-1:0]        best_score;
    logic [CLASS_W-1:0]        class_index;
    logic [ROW_W-1:0]          row_index;
  } out_item_t;

  // Finished row waiting for its corner multiplies
  typedef struct packed {
    logic signed [VAL_W-1:0] center_x;
    logic signed [VAL_W-1:0] center_y;
    logic signed [VAL_W-1:0] box_width;
    logic signed [VAL_W-1:0] box_height;
    logic [SCORE_W-1:0]      score;
    logic [CLASS_W-1:0]      class_idx;
    logic [ROW_W-1:0]        row_idx;
  } cand_t;

endpackage

/* src/dbd_corner.sv */
// Corner pair for one axis: (c -/+ (size >>> 1)) * dim >>> 12, as signed Q.4 pixels.
// Depends on dbd_pkg for widths.
module dbd_corner import dbd_pkg::*; (
  input  logic signed [VAL_W-1:0]   center_i,
  input  logic signed [VAL_W-1:0]   size_i,
  input  logic [DIM_W-1:0]          dim_i,
  output logic signed [COORD_W-1:0] lo_o,
  output logic signed [COORD_W-1:0] hi_o
);

  localparam int unsigned EDGE_W = VAL_W + 1;
  localparam int unsigned PROD_W = EDGE_W + DIM_W + 1;

  logic signed [VAL_W-1:0]  half;
  logic signed [EDGE_W-1:0] edge_lo, edge_hi;
  logic signed [DIM_W:0]    dim_s;
  logic signed [PROD_W-1:0] prod_lo, prod_hi;

  assign half    = size_i >>> 1;
  assign edge_lo = EDGE_W'(center_i) - EDGE_W'(half);
  assign edge_hi = EDGE_W'(center_i) + EDGE_W'(half);
  assign dim_s   = $signed({1'b0, dim_i});
  assign prod_lo = PROD_W'(edge_lo) * PROD_W'(dim_s);
  assign prod_hi = PROD_W'(edge_hi) * PROD_W'(dim_s);

  // drop twelve fraction bits, keep the sign
  assign lo_o = COORD_W'(prod_lo >>> 12);
  assign hi_o = COORD_W'(prod_hi >>> 12);

endmodule

/* src/detection_box_decoder_top.sv */
// Detection box decoder: one int8 tensor element per cycle unless stalled; a result
// passes the input register, row scan register and corner/output register in turn.
// Throughput: one element per cycle unless stalled; scan register feeds own compare.
// A result leaves at most once per row, on the last score element.
// Reset (rst_ni low, asynchronous) empties all stages, loads the register defaults
// and restarts the row at position 0, row 0, running maximum -1.0.
module detection_box_decoder_top import dbd_pkg::*; #(
  parameter int unsigned MAX_CLASSES    = MAX_CLASSES_DEF,
  parameter int unsigned ROW_INDEX_BITS = ROW_INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // element requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  // detection results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  // position counter wide enough for the four box slots plus every class slot
  localparam int unsigned POS_W = $clog2(MAX_CLASSES + 4);
  localparam logic [7:0]  MaxCls = 8'(MAX_CLASSES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]         class_count_q;
  logic signed [7:0]  in_offset_q;
  logic [15:0]        scale_q;
  logic [SCORE_W-1:0] threshold_q;
  logic [DIM_W-1:0]   img_width_q, img_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      in_offset_q   <= IN_OFFSET_RST;
      scale_q       <= SCALE_RST;
      threshold_q   <= THRESHOLD_RST;
      img_width_q   <= WIDTH_RST;
      img_height_q  <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CLASS_COUNT: class_count_q <= cfg_wdata_i[7:0];
        CFG_IN_OFFSET:   in_offset_q   <= $signed(cfg_wdata_i[7:0]);
        CFG_SCALE:       scale_q       <= cfg_wdata_i[15:0];
        CFG_THRESHOLD:   threshold_q   <= cfg_wdata_i[SCORE_W-1:0];
        CFG_IMG_WIDTH:   img_width_q   <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMG_HEIGHT:  img_height_q  <= cfg_wdata_i[DIM_W-1:0];
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage takes a new entry when empty or when it drains
  // ---------------------------------------------------------------------------
  logic     in_valid_q;
  in_item_t in_q;
  logic     cand_valid_q, cand_valid_d;
  cand_t    cand_q, cand_d;
  logic     out_valid_q;
  out_item_t out_q, out_d;

  logic rdy_in, rdy_cand, rdy_out;
  logic adv_in;

  assign rdy_out  = !out_valid_q || out_ready_i;
  assign rdy_cand = !cand_valid_q || rdy_out;
  assign rdy_in   = !in_valid_q || rdy_cand;
  assign adv_in   = in_valid_q && rdy_cand;  // scan stage consumes one element

  assign in_ready_o = rdy_in;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rdy_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_in && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Row scan: dequantize, capture the box, keep the running argmax
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]          pos_q, pos_d, pos_eff, last_pos;
  logic [ROW_INDEX_BITS-1:0] row_q, row_d, row_eff;
  logic signed [VAL_W-1:0]   cx_q, cy_q, bw_q, bh_q;
  logic signed [VAL_W-1:0]   max_q, max_d;
  logic [CLASS_W-1:0]        cls_q, cls_d;
  logic [7:0]                ncls;
  logic signed [8:0]         diff;
  logic signed [25:0]        prod;
  logic signed [VAL_W-1:0]   val;
  logic                      is_last;

  // clamp the class count to 1..MAX_CLASSES
  always_comb begin
    ncls = class_count_q;
    if (ncls == 8'd0) begin
      ncls = 8'd1;
    end else if (ncls > MaxCls) begin
      ncls = MaxCls;
    end
  end

  assign last_pos = POS_W'(ncls) + POS_W'(3);

  // frame start restarts the row; a stale position past the end restarts it too
  assign pos_eff = (in_q.frame_start || (pos_q > last_pos)) ? '0 : pos_q;
  assign row_eff = in_q.frame_start ? '0 : row_q;
  assign is_last = (pos_eff == last_pos);

  // (raw - offset) * scale is exact in 25 bits
  assign diff = 9'(in_q.raw_value) - 9'(in_offset_q);
  assign prod = 26'(diff) * $signed({10'd0, scale_q});
  assign val  = prod[VAL_W-1:0];

  always_comb begin
    max_d = max_q;
    cls_d = cls_q;
    unique case (pos_eff)
      POS_W'(0): begin
        max_d = MINUS_ONE_Q16;
        cls_d = '0;
      end
      POS_W'(1), POS_W'(2), POS_W'(3): ;
      default: begin
        // strict compare: the first maximum keeps its class
        if (val > max_q) begin
          max_d = val;
          cls_d = CLASS_W'(pos_eff - POS_W'(4));
        end
      end
    endcase
    pos_d = is_last ? '0 : pos_eff + POS_W'(1);
    row_d = is_last ? row_eff + ROW_INDEX_BITS'(1) : row_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= '0;
      max_q <= MINUS_ONE_Q16;
      cls_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
      bw_q  <= '0;
      bh_q  <= '0;
    end else if (adv_in) begin
      pos_q <= pos_d;
      row_q <= row_d;
      max_q <= max_d;
      cls_q <= cls_d;
      if (pos_eff == POS_W'(0)) cx_q <= val;
      if (pos_eff == POS_W'(1)) cy_q <= val;
      if (pos_eff == POS_W'(2)) bw_q <= val;
      if (pos_eff == POS_W'(3)) bh_q <= val;
    end
  end

  // end of row: hand on a candidate when the best score clears the threshold
  always_comb begin
    cand_valid_d        = is_last && (max_d > $signed({1'b0, threshold_q}));
    cand_d.center_x     = cx_q;
    cand_d.center_y     = cy_q;
    cand_d.box_width    = bw_q;
    cand_d.box_height   = bh_q;
    cand_d.score        = max_d[SCORE_W-1:0];
    cand_d.class_idx    = cls_d;
    cand_d.row_idx      = ROW_W'(row_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
    end else if (rdy_cand) begin
      cand_valid_q <= in_valid_q && cand_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && cand_valid_d) begin
      cand_q <= cand_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Corner multiplies into the output register
  // ---------------------------------------------------------------------------
  dbd_corner u_corner_x (
    .center_i (cand_q.center_x),
    .size_i   (cand_q.box_width),
    .dim_i    (img_width_q),
    .lo_o     (out_d.left_x),
    .hi_o     (out_d.right_x)
  );

  dbd_corner u_corner_y (
    .center_i (cand_q.center_y),
    .size_i   (cand_q.box_height),
    .dim_i    (img_height_q),
    .lo_o     (out_d.top_y),
    .hi_o     (out_d.bottom_y)
  );

  assign out_d.best_score  = cand_q.score;
  assign out_d.class_index = cand_q.class_idx;
  assign out_d.row_index   = cand_q.row_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= cand_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && cand_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/dbd_checker.sv */
// Port-level checks for the detection box decoder, bound to the top level.
// Depends on dbd_pkg and detection_box_decoder_top.
module dbd_checker import dbd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_item_i))
    else $error("result payload changed while stalled");

  // with the output free or draining, every stage can move, so requests flow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("request stalled with output side free");

  // a result only leaves when the score beat a non-negative threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.best_score != '0))
    else $error("result with zero score");

  // class index never reaches the all-ones code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.class_index != 8'hFF))
    else $error("class index out of range");

endmodule

bind detection_box_decoder_top dbd_checker u_dbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

/* test/detection_box_decoder_tb.sv */
// Self-checking testbench for detection_box_decoder_top: a short stimulus table, a counted
// output hold-off, then random tensor rows over many register settings and idling phases.
// Depends on dbd_pkg and detection_box_decoder_top; needs nothing else.
module testbench;
  import dbd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 8;    // comfortably beyond the three-stage latency
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off in the pressure phase

  // How a table row is checked: by the predictor, or against a typed-in outcome
  typedef enum logic [1:0] {
    BY_MODEL,
    WANT_NONE,
    WANT_RESULT
  } check_e;

  typedef struct packed {
    logic signed [7:0] raw;
    logic              fs;
    check_e            chk;
    out_item_t         want;
  } stim_row_t;

  localparam out_item_t NO_BOX    = '0;
  // First row after reset: empty box at the origin, score 1.0 - 1/65536, class 0, row 0
  localparam out_item_t FIRST_HIT = '{28'sd0, 28'sd0, 28'sd0, 28'sd0, 24'd65535, 8'd0, 16'd0};

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;

  // Detections predicted for accepted requests, oldest first
  out_item_t detections [$];
  int        fail_cnt  = 0;
  int        cycle_cnt = 0;

  // Idling controls: the sender gap is used by the stimulus process only,
  // the stall share and the hold-off request are read by the receiver
  int send_gap_pct = 0;
  int stall_pct    = 0;
  logic hold_on    = 1'b0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;

  // Scores per row for the random phases: mostly short rows, the widest only twice
  int unsigned class_plan [12] = '{1, 0, 4, 255, 2, 7, 1, 3, 255, 5, 2, 8};

  // Predictor copy of the registers
  logic [7:0]        cfg_classes = CLASS_COUNT_RST;
  logic signed [7:0] cfg_zp      = IN_OFFSET_RST;
  logic [15:0]       cfg_scale   = SCALE_RST;
  logic [23:0]       cfg_thr     = THRESHOLD_RST;
  logic [11:0]       cfg_w       = WIDTH_RST;
  logic [11:0]       cfg_h       = HEIGHT_RST;

  // Predictor copy of the row state
  logic [8:0]  pos_q    = '0;
  int          ctr_x    = 0;
  int          ctr_y    = 0;
  int          size_w   = 0;
  int          size_h   = 0;
  int          best_val = -65536;
  logic [7:0]  best_cls = '0;
  logic [15:0] row_cnt  = '0;

  detection_box_decoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Corner in Q.4 pixels: centre minus or plus half the size, scaled by the
  // image dimension; both shifts round toward minus infinity
  function automatic logic [27:0] corner_px(input int c, input int size, input bit plus,
                                            input logic [11:0] dim);
    longint half;
    longint e;
    longint p;
    half = longint'(size) >>> 1;
    e    = plus ? longint'(c) + half : longint'(c) - half;
    p    = (e * longint'(dim)) >>> 12;
    return p[27:0];
  endfunction

  // Advance the row state by one element; return 1 with the detection when
  // the row closes above the threshold
  function automatic bit decode_element(input in_item_t it, output out_item_t res);
    int unsigned eff;
    logic [8:0]  last;
    int          v;
    bit          hit;
    hit = 1'b0;
    res = '0;
    // class count of zero behaves as one
    eff  = (cfg_classes == 8'd0) ? 1 : int'(cfg_classes);
    last = 9'(3 + eff);
    if (it.frame_start) begin
      pos_q   = '0;
      row_cnt = '0;
    end
    // a shorter row setting leaves the position past the end: restart the row
    if (pos_q > last) pos_q = '0;
    v = (int'(it.raw_value) - int'(cfg_zp)) * int'(cfg_scale);
    case (pos_q)
      9'd0: begin
        ctr_x    = v;
        best_val = -65536;
        best_cls = '0;
      end
      9'd1: ctr_y  = v;
      9'd2: size_w = v;
      9'd3: size_h = v;
      default: begin
        // strictly greater, so the first of equal scores keeps the class
        if (v > best_val) begin
          best_val = v;
          best_cls = 8'(pos_q - 9'd4);
        end
      end
    endcase
    if (pos_q == last) begin
      if (best_val > int'(cfg_thr)) begin
        res.left_x      = corner_px(ctr_x, size_w, 1'b0, cfg_w);
        res.top_y       = corner_px(ctr_y, size_h, 1'b0, cfg_h);
        res.right_x     = corner_px(ctr_x, size_w, 1'b1, cfg_w);
        res.bottom_y    = corner_px(ctr_y, size_h, 1'b1, cfg_h);
        res.best_score  = best_val[23:0];
        res.class_index = best_cls;
        res.row_index   = row_cnt;
        hit = 1'b1;
      end
      row_cnt = row_cnt + 16'd1;
      pos_q   = '0;
    end else begin
      pos_q = pos_q + 9'd1;
    end
    return hit;
  endfunction

  function automatic int field_diff(input string name, input logic signed [31:0] exp,
                                    input logic signed [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  // Hold ready low for a counted stretch once asked, otherwise stall at the phase's share
  always @(negedge clk_i) begin
    if (hold_on && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every accepted detection with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (detections.size() == 0) begin
        $error("detection with no request behind it: row_index %0d", out_item.row_index);
        fail_cnt++;
      end else begin
        want = detections.pop_front();
        fail_cnt += field_diff("left_x", want.left_x, out_item.left_x);
        fail_cnt += field_diff("top_y", want.top_y, out_item.top_y);
        fail_cnt += field_diff("right_x", want.right_x, out_item.right_x);
        fail_cnt += field_diff("bottom_y", want.bottom_y, out_item.bottom_y);
        fail_cnt += field_diff("best_score", want.best_score, out_item.best_score);
        fail_cnt += field_diff("class_index", want.class_index, out_item.class_index);
        fail_cnt += field_diff("row_index", want.row_index, out_item.row_index);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("detection_box_decoder_top: mismatch");
      $finish;
    end
  end

  // Write one register and mirror it in the predictor; start and end at a falling edge
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CLASS_COUNT: cfg_classes = val[7:0];
      CFG_IN_OFFSET:   cfg_zp      = val[7:0];
      CFG_SCALE:       cfg_scale   = val[15:0];
      CFG_THRESHOLD:   cfg_thr     = val[23:0];
      CFG_IMG_WIDTH:   cfg_w       = val[11:0];
      CFG_IMG_HEIGHT:  cfg_h       = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one request after a random gap, hold it until taken, then predict
  task automatic put_element(input in_item_t it, input check_e chk, input out_item_t want);
    out_item_t pred;
    bit        hit;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    hit = decode_element(it, pred);
    if (chk == BY_MODEL && hit) detections = {detections, pred};
    else if (chk == WANT_RESULT) detections = {detections, want};
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every detection, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (detections.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_gap_pct = 65; stall_pct <= 0;  end
      2: begin send_gap_pct = 0;  stall_pct <= 65; end
      3: begin send_gap_pct = 35; stall_pct <= 35; end
      default: begin send_gap_pct = 0; stall_pct <= 0; end
    endcase
  endtask

  // Random register setting around the given class count, extremes included
  task automatic new_setting(input logic [7:0] cc);
    logic signed [7:0] zp;
    logic [15:0]       sc;
    logic [23:0]       thr;
    logic [11:0]       w;
    logic [11:0]       h;
    case ($urandom_range(4))
      0: zp = -8'sd128;
      1: zp = 8'sd127;
      2: zp = 8'sd0;
      default: zp = 8'($urandom);
    endcase
    case ($urandom_range(7))
      0: sc = 16'd0;
      1: sc = 16'hFFFF;
      2: sc = 16'd1;
      3: sc = 16'd256;
      default: sc = 16'($urandom);
    endcase
    // multiples of the scale land exactly on reachable scores, to hit equality
    case ($urandom_range(5))
      0: thr = 24'd0;
      1: thr = 24'hFFFFFF;
      5: thr = 24'($urandom);
      default: thr = 24'($urandom_range(120) * sc);
    endcase
    case ($urandom_range(4))
      0: w = 12'd0;
      1: w = 12'hFFF;
      default: w = 12'($urandom);
    endcase
    case ($urandom_range(4))
      0: h = 12'd0;
      1: h = 12'hFFF;
      default: h = 12'($urandom);
    endcase
    write_reg(CFG_CLASS_COUNT, cc);
    write_reg(CFG_IN_OFFSET, zp);
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_IMG_WIDTH, w);
    write_reg(CFG_IMG_HEIGHT, h);
  endtask

  // Mostly whole rows with random content; now and then a new frame, a cut-off
  // row resynchronised by frame_start, a stray frame_start, or a repeated score
  task automatic random_phase(input int target);
    in_item_t          it;
    int                sent;
    int                len;
    int                rowlen;
    int                k;
    bit                resync;
    logic signed [7:0] prev;
    sent   = 0;
    resync = $urandom_range(1);
    rowlen = 4 + ((cfg_classes == 8'd0) ? 1 : int'(cfg_classes));
    prev   = '0;
    while (sent < target) begin
      len            = rowlen;
      it.frame_start = resync || ($urandom_range(15) == 0);
      resync         = 1'b0;
      if ($urandom_range(19) == 0) begin
        len    = $urandom_range(rowlen, 1);
        resync = 1'b1;
      end
      for (k = 0; k < len; k++) begin
        it.raw_value = 8'($urandom);
        if (k >= 4 && $urandom_range(7) == 0) it.raw_value = prev;
        prev = it.raw_value;
        if (k != 0) it.frame_start = ($urandom_range(99) == 0);
        put_element(it, BY_MODEL, NO_BOX);
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    stim_row_t stim_rows [$];
    in_item_t  it;
    int        p;

    // Hold reset, release on a falling edge
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: two scores per row and full-range scale; zero point,
    // threshold and image size stay at their reset values
    set_idling(0);
    write_reg(CFG_CLASS_COUNT, 24'd2);
    write_reg(CFG_SCALE, 24'hFFFF);

    // First row of a frame: empty box, tied scores, the first one wins
    stim_rows = {stim_rows, stim_row_t'{8'sd0, 1'b1, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd0, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd0, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd0, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd1, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd1, 1'b0, WANT_RESULT, FIRST_HIT}};
    // Extreme box values, second score wins
    stim_rows = {stim_rows, stim_row_t'{8'sd127, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd128, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd127, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd128, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd128, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd127, 1'b0, BY_MODEL, NO_BOX}};
    // No score above minus one: nothing leaves
    stim_rows = {stim_rows, stim_row_t'{8'sd5, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd6, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd7, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd8, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd128, 1'b0, WANT_NONE, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd128, 1'b0, WANT_NONE, NO_BOX}};
    // Row cut after one element by a new frame
    stim_rows = {stim_rows, stim_row_t'{8'sd3, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{-8'sd1, 1'b1, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd2, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd10, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd20, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd0, 1'b0, BY_MODEL, NO_BOX}};
    stim_rows = {stim_rows, stim_row_t'{8'sd1, 1'b0, BY_MODEL, NO_BOX}};

    foreach (stim_rows[i]) begin
      it.raw_value   = stim_rows[i].raw;
      it.frame_start = stim_rows[i].fs;
      put_element(it, stim_rows[i].chk, stim_rows[i].want);
    end
    wait_idle();

    // Pressure: one score per row and a zero threshold, so nearly every row
    // detects; the receiver holds off while requests keep coming
    write_reg(CFG_CLASS_COUNT, 24'd1);
    write_reg(CFG_IN_OFFSET, 24'h80);
    write_reg(CFG_SCALE, 24'd256);
    write_reg(CFG_THRESHOLD, 24'd0);
    write_reg(CFG_IMG_WIDTH, 24'(12'($urandom)));
    write_reg(CFG_IMG_HEIGHT, 24'hFFF);
    hold_on <= 1'b1;
    random_phase(300);
    wait_idle();

    // Random phases, cycling through the idling patterns
    for (p = 0; p < 12; p++) begin
      set_idling(p % 4);
      new_setting(8'(class_plan[p]));
      random_phase(110);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("detection_box_decoder_top: match");
    end else begin
      $display("detection_box_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
